[sv/mml_pkg.sv]
// shared types, codes and constant tables for the mml text to note events block
// no dependencies
package mml_pkg;

  localparam int NumBits   = 16;
  localparam int DivSteps  = 19;
  localparam logic [18:0] NUM_PLAIN  = 19'd240000;
  localparam logic [18:0] NUM_DOTTED = 19'd360000;
  localparam logic [NumBits-1:0] NUM_MAX = '1;

  typedef enum logic [2:0] {
    K_NOTE   = 3'd0,
    K_REST   = 3'd1,
    K_OCTAVE = 3'd2,
    K_TEMPO  = 3'd3,
    K_VOLUME = 3'd4,
    K_ARTIC  = 3'd5,
    K_ERROR  = 3'd6,
    K_END    = 3'd7
  } kind_t;

  typedef enum logic [13:0] {
    PH_IDLE        = 14'b00000000000001,
    PH_NOTE_MOD    = 14'b00000000000010,
    PH_NOTE_NUM    = 14'b00000000000100,
    PH_NOTE_DOT    = 14'b00000000001000,
    PH_REST_NUM    = 14'b00000000010000,
    PH_REST_DOT    = 14'b00000000100000,
    PH_OCT         = 14'b00000001000000,
    PH_TEMPO_START = 14'b00000010000000,
    PH_TEMPO_NUM   = 14'b00000100000000,
    PH_TEMPO_SKIP  = 14'b00001000000000,
    PH_LEN         = 14'b00010000000000,
    PH_VOL         = 14'b00100000000000,
    PH_ART         = 14'b01000000000000,
    PH_HALT        = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [NumBits-1:0] acc;
    logic               digit;
    logic [3:0]         pitch;
    logic [1:0]         dots;
    logic [2:0]         oct;
    logic [7:0]         tempo;
    logic [6:0]         deflen;
    logic [3:0]         vol;
    logic [1:0]         art;
  } pstate_t;

  typedef struct packed {
    kind_t              kind;
    logic [18:0]        freq;
    logic [NumBits-1:0] len;
    logic               dotted;
    logic [7:0]         tempo;
    logic [7:0]         value;
    logic               timed;
  } res_t;

  typedef struct packed {
    pstate_t    st;
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } step_t;

  function automatic pstate_t reset_state();
    pstate_t s;
    s.phase  = PH_IDLE;
    s.acc    = '0;
    s.digit  = 1'b0;
    s.pitch  = 4'd0;
    s.dots   = 2'd0;
    s.oct    = 3'd4;
    s.tempo  = 8'd120;
    s.deflen = 7'd4;
    s.vol    = 4'd8;
    s.art    = 2'd0;
    return s;
  endfunction

  // octave 4 pitches c..b, 16 fraction bits
  function automatic logic [24:0] pitch_q16(input logic [3:0] p);
    logic [24:0] v;
    case (p)
      4'd0:    v = 25'd17146184;
      4'd1:    v = 25'd18165268;
      4'd2:    v = 25'd19245302;
      4'd3:    v = 25'd20390216;
      4'd4:    v = 25'd21602632;
      4'd5:    v = 25'd22887137;
      4'd6:    v = 25'd24247665;
      4'd7:    v = 25'd25690112;
      4'd8:    v = 25'd27217101;
      4'd9:    v = 25'd28835840;
      4'd10:   v = 25'd30550262;
      4'd11:   v = 25'd32366920;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] letter_pitch(input logic [2:0] l);
    logic [3:0] v;
    case (l)
      3'd0:    v = 4'd9;
      3'd1:    v = 4'd11;
      3'd2:    v = 4'd0;
      3'd3:    v = 4'd2;
      3'd4:    v = 4'd4;
      3'd5:    v = 4'd5;
      3'd6:    v = 4'd7;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/mml_in_if.sv]
// text input channel: one character per transaction
// depends on nothing
interface mml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

[sv/mml_out_if.sv]
// event output channel: one event per transaction
// depends on nothing
interface mml_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [18:0] frequency;
  logic [13:0] duration_ms;
  logic [7:0]  value;
  logic        done_res;
  modport source (output valid, kind, frequency, duration_ms, value, done_res, input ready);
  modport sink (input valid, kind, frequency, duration_ms, value, done_res, output ready);
endinterface

[sv/mml_cfg_if.sv]
// configuration write channel carrying strict_mode
// depends on nothing
interface mml_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;
  modport source (output valid, strict_mode, input ready);
  modport sink (input valid, strict_mode, output ready);
endinterface

[sv/mml_parse.sv]
// character decoder: one parse step from the held state and a character
// depends on mml_pkg
module mml_parse (
  input  mml_pkg::pstate_t st,
  input  logic [7:0]       character,
  input  logic             last,
  input  logic             strict_mode,
  output mml_pkg::step_t   step
);

  typedef struct packed {
    mml_pkg::pstate_t s;
    logic             has;
    mml_pkg::res_t    r;
  } act_t;

  typedef struct packed {
    act_t a;
    logic ok;
  } ext_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

  function automatic mml_pkg::res_t mk(input mml_pkg::kind_t k, input logic [7:0] v);
    mml_pkg::res_t r;
    r = '0;
    r.kind  = k;
    r.value = v;
    return r;
  endfunction

  function automatic mml_pkg::pstate_t clear_parse(input mml_pkg::pstate_t s);
    mml_pkg::pstate_t t;
    t       = s;
    t.phase = mml_pkg::PH_IDLE;
    t.acc   = '0;
    t.digit = 1'b0;
    t.pitch = 4'd0;
    t.dots  = 2'd0;
    return t;
  endfunction

  function automatic mml_pkg::pstate_t take_digit(input mml_pkg::pstate_t s,
                                                 input logic [7:0] c);
    mml_pkg::pstate_t t;
    logic [mml_pkg::NumBits+3:0] v;
    t = s;
    v = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1)
        + {{mml_pkg::NumBits{1'b0}}, 4'(c - "0")};
    t.acc   = (v > {4'd0, mml_pkg::NUM_MAX}) ? mml_pkg::NUM_MAX : v[mml_pkg::NumBits-1:0];
    t.digit = 1'b1;
    return t;
  endfunction

  function automatic act_t do_finish(input mml_pkg::pstate_t s);
    act_t a;
    logic [mml_pkg::NumBits-1:0] len;
    logic [30:0] f;
    a.s   = s;
    a.has = 1'b0;
    a.r   = '0;
    len = s.digit ? s.acc : mml_pkg::NumBits'(s.deflen);
    if (len == '0) len = mml_pkg::NumBits'(s.deflen);
    f = {6'd0, mml_pkg::pitch_q16(s.pitch)} << s.oct;
    unique case (s.phase)
      mml_pkg::PH_NOTE_MOD, mml_pkg::PH_NOTE_NUM, mml_pkg::PH_NOTE_DOT: begin
        a.has      = 1'b1;
        a.r        = mk(mml_pkg::K_NOTE, 8'd0);
        a.r.freq   = f[30:12];
        a.r.len    = len;
        a.r.dotted = (s.dots != 2'd0);
        a.r.tempo  = s.tempo;
        a.r.timed  = 1'b1;
      end
      mml_pkg::PH_REST_NUM, mml_pkg::PH_REST_DOT: begin
        a.has      = 1'b1;
        a.r        = mk(mml_pkg::K_REST, 8'd0);
        a.r.len    = len;
        a.r.dotted = (s.dots != 2'd0);
        a.r.tempo  = s.tempo;
        a.r.timed  = 1'b1;
      end
      mml_pkg::PH_OCT: begin
        if (s.digit) a.s.oct = (s.acc > 6) ? 3'd6 : s.acc[2:0];
        a.has = 1'b1;
        a.r   = mk(mml_pkg::K_OCTAVE, {5'd0, a.s.oct});
      end
      mml_pkg::PH_TEMPO_START, mml_pkg::PH_TEMPO_NUM: begin
        if (s.digit) begin
          a.s.tempo = (s.acc < 32) ? 8'd32 : ((s.acc > 255) ? 8'd255 : s.acc[7:0]);
        end
        a.has = 1'b1;
        a.r   = mk(mml_pkg::K_TEMPO, a.s.tempo);
      end
      mml_pkg::PH_LEN: begin
        if (s.digit) a.s.deflen = ((s.acc >= 1) && (s.acc <= 64)) ? s.acc[6:0] : 7'd4;
      end
      mml_pkg::PH_VOL: begin
        if (s.digit) a.s.vol = (s.acc > 15) ? 4'd15 : s.acc[3:0];
        a.has = 1'b1;
        a.r   = mk(mml_pkg::K_VOLUME, {4'd0, a.s.vol});
      end
      default: ;
    endcase
    if (s.phase != mml_pkg::PH_HALT) a.s = clear_parse(a.s);
    return a;
  endfunction

  function automatic ext_t do_extend(input mml_pkg::pstate_t s, input logic [7:0] c);
    ext_t e;
    logic [7:0] m;
    e.a.s   = s;
    e.a.has = 1'b0;
    e.a.r   = '0;
    e.ok    = 1'b0;
    m       = upper(c);
    unique case (s.phase)
      mml_pkg::PH_NOTE_MOD, mml_pkg::PH_NOTE_NUM: begin
        if ((s.phase == mml_pkg::PH_NOTE_MOD) && ((c == "#") || (c == "+"))) begin
          e.a.s.pitch = (s.pitch == 4'd11) ? 4'd0 : s.pitch + 4'd1;
          e.a.s.phase = mml_pkg::PH_NOTE_NUM;
          e.ok        = 1'b1;
        end else if ((s.phase == mml_pkg::PH_NOTE_MOD) && (c == "-")) begin
          e.a.s.pitch = (s.pitch == 4'd0) ? 4'd11 : s.pitch - 4'd1;
          e.a.s.phase = mml_pkg::PH_NOTE_NUM;
          e.ok        = 1'b1;
        end else if (is_digit(c)) begin
          e.a.s       = take_digit(s, c);
          e.a.s.phase = mml_pkg::PH_NOTE_NUM;
          e.ok        = 1'b1;
        end else if (c == ".") begin
          e.a.s.dots  = 2'd1;
          e.a.s.phase = mml_pkg::PH_NOTE_DOT;
          e.ok        = 1'b1;
        end
      end
      mml_pkg::PH_NOTE_DOT: begin
        if ((c == ".") && (s.dots < 2'd3)) begin
          e.a.s.dots = s.dots + 2'd1;
          e.ok       = 1'b1;
        end
      end
      mml_pkg::PH_REST_NUM: begin
        if (is_digit(c)) begin
          e.a.s = take_digit(s, c);
          e.ok  = 1'b1;
        end else if (c == ".") begin
          e.a.s.dots  = 2'd1;
          e.a.s.phase = mml_pkg::PH_REST_DOT;
          e.ok        = 1'b1;
        end
      end
      mml_pkg::PH_REST_DOT: begin
        if (c == ".") begin
          if (s.dots < 2'd3) e.a.s.dots = s.dots + 2'd1;
          e.ok = 1'b1;
        end
      end
      mml_pkg::PH_OCT, mml_pkg::PH_LEN, mml_pkg::PH_VOL, mml_pkg::PH_TEMPO_NUM: begin
        if (is_digit(c)) begin
          e.a.s = take_digit(s, c);
          e.ok  = 1'b1;
        end
      end
      mml_pkg::PH_TEMPO_START: begin
        if (c == "=") begin
          e.a.s.phase = mml_pkg::PH_TEMPO_SKIP;
          e.ok        = 1'b1;
        end else if (is_digit(c)) begin
          e.a.s       = take_digit(s, c);
          e.a.s.phase = mml_pkg::PH_TEMPO_NUM;
          e.ok        = 1'b1;
        end
      end
      mml_pkg::PH_TEMPO_SKIP: begin
        if (is_alpha(c) || (c == "<") || (c == ">")) e.a.s = clear_parse(s);
        else e.ok = 1'b1;
      end
      mml_pkg::PH_ART: begin
        if (m == "L") e.a.s.art = 2'd1;
        else if (m == "N") e.a.s.art = 2'd0;
        else if (m == "S") e.a.s.art = 2'd2;
        e.a.has = 1'b1;
        e.a.r   = mk(mml_pkg::K_ARTIC, {6'd0, e.a.s.art});
        e.a.s   = clear_parse(e.a.s);
        e.ok    = 1'b1;
      end
      mml_pkg::PH_HALT: e.ok = 1'b1;
      default: ;
    endcase
    return e;
  endfunction

  function automatic act_t do_command(input mml_pkg::pstate_t s, input logic [7:0] c,
                                      input logic strict);
    act_t a;
    logic [7:0] u;
    a.s       = s;
    a.has     = 1'b0;
    a.r       = '0;
    u         = upper(c);
    a.s.acc   = '0;
    a.s.digit = 1'b0;
    a.s.dots  = 2'd0;
    if (!is_space(c)) begin
      if ((u >= "A") && (u <= "G")) begin
        a.s.pitch = mml_pkg::letter_pitch(3'(u - "A"));
        a.s.phase = mml_pkg::PH_NOTE_MOD;
      end else begin
        case (u)
          "R", "P": a.s.phase = mml_pkg::PH_REST_NUM;
          "O":      a.s.phase = mml_pkg::PH_OCT;
          "T":      a.s.phase = mml_pkg::PH_TEMPO_START;
          "L":      a.s.phase = mml_pkg::PH_LEN;
          "V":      a.s.phase = mml_pkg::PH_VOL;
          "M":      a.s.phase = mml_pkg::PH_ART;
          "<": begin
            a.s.oct = (s.oct != 3'd0) ? s.oct - 3'd1 : 3'd0;
            a.has   = 1'b1;
            a.r     = mk(mml_pkg::K_OCTAVE, {5'd0, a.s.oct});
          end
          ">": begin
            a.s.oct = (s.oct >= 3'd6) ? 3'd6 : s.oct + 3'd1;
            a.has   = 1'b1;
            a.r     = mk(mml_pkg::K_OCTAVE, {5'd0, a.s.oct});
          end
          default: begin
            if (strict) begin
              a.has     = 1'b1;
              a.r       = mk(mml_pkg::K_ERROR, 8'd0);
              a.s.phase = mml_pkg::PH_HALT;
            end
          end
        endcase
      end
    end
    return a;
  endfunction

  always_comb begin
    mml_pkg::pstate_t s;
    mml_pkg::res_t    rr0;
    mml_pkg::res_t    rr1;
    logic [1:0]       cnt;
    act_t             a [3];
    ext_t             e;
    s    = st;
    rr0  = '0;
    rr1  = '0;
    cnt  = 2'd0;
    a[0] = '0;
    a[1] = '0;
    a[2] = '0;
    e    = do_extend(s, character);
    if (s.phase == mml_pkg::PH_IDLE || !e.ok) begin
      if (s.phase != mml_pkg::PH_IDLE) begin
        s    = e.a.s;
        if (s.phase != mml_pkg::PH_IDLE) begin
          a[0] = do_finish(s);
          s    = a[0].s;
        end
      end
      if (s.phase == mml_pkg::PH_IDLE) begin
        a[1] = do_command(s, character, strict_mode);
        s    = a[1].s;
      end
    end else begin
      a[0] = e.a;
      s    = e.a.s;
    end
    if (last) begin
      a[2] = do_finish(s);
      s    = mml_pkg::reset_state();
    end
    for (int i = 0; i < 3; i++) begin
      if (a[i].has) begin
        if (cnt == 2'd0) rr0 = a[i].r;
        else if (cnt == 2'd1) rr1 = a[i].r;
        if (cnt != 2'd2) cnt = cnt + 2'd1;
      end
    end
    if (last && cnt == 2'd0) begin
      rr0 = mk(mml_pkg::K_END, 8'd0);
      cnt = 2'd1;
    end
    step.st  = s;
    step.r0  = rr0;
    step.r1  = rr1;
    step.cnt = cnt;
  end

endmodule

[sv/mml_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on mml_pkg
module mml_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [18:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [13:0] quot
);

  logic        busy;
  logic [4:0]  count;
  logic [18:0] nsh;
  logic [23:0] rem;
  logic [18:0] q;
  logic [24:0] trial;
  logic        fits;

  assign trial = {rem, nsh[18]};
  assign fits  = (trial >= {1'b0, den});
  assign quot  = q[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'(mml_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= num;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      nsh <= {nsh[17:0], 1'b0};
      rem <= fits ? 24'(trial - {1'b0, den}) : trial[23:0];
      q   <= {q[17:0], fits};
    end
  end

endmodule

[sv/mml_text_to_note_events.sv]
// mml text to note events top level: holds parse state, sequences results
// depends on mml_pkg, mml_in_if, mml_out_if, mml_cfg_if, mml_parse, mml_div
//
// One character is taken per transaction; txt.ready is low while its events are
// produced. A character steps the parser in SQ_STEP, then each event passes SQ_LOAD
// and SQ_OUT plus the wait on evt.ready; a note or rest also passes SQ_DIVGO and
// SQ_DIV, where the shared 19-step divider turns 240000 or 360000 over length times
// tempo into ms. A character yields at most two events. strict_mode takes effect from
// the next character and is to be written while the block is idle.
module mml_text_to_note_events (
  input logic      clk,
  input logic      rst,
  mml_in_if.sink   txt,
  mml_out_if.source evt,
  mml_cfg_if.sink  cfg
);

  typedef enum logic [5:0] {
    SQ_IDLE  = 6'b000001,
    SQ_STEP  = 6'b000010,
    SQ_LOAD  = 6'b000100,
    SQ_DIVGO = 6'b001000,
    SQ_DIV   = 6'b010000,
    SQ_OUT   = 6'b100000
  } seq_t;

  seq_t             seq;
  logic             strict_mode;
  mml_pkg::pstate_t pst;
  mml_pkg::step_t   step;
  mml_pkg::res_t    res0;
  mml_pkg::res_t    res1;
  mml_pkg::res_t    cur;
  logic [1:0]       cnt;
  logic             idx;
  logic [7:0]       chr;
  logic             lst;
  logic [23:0]      den;
  logic             div_done;
  logic [13:0]      div_q;

  assign cfg.ready = 1'b1;
  assign txt.ready = (seq == SQ_IDLE);
  assign evt.valid = (seq == SQ_OUT);
  assign cur       = idx ? res1 : res0;

  mml_parse u_parse (
    .st          (pst),
    .character   (chr),
    .last        (lst),
    .strict_mode (strict_mode),
    .step        (step)
  );

  mml_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (seq == SQ_DIVGO),
    .num   (cur.dotted ? mml_pkg::NUM_DOTTED : mml_pkg::NUM_PLAIN),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SQ_IDLE;
      strict_mode <= 1'b0;
      pst         <= mml_pkg::reset_state();
      idx         <= 1'b0;
      cnt         <= 2'd0;
    end else begin
      if (cfg.valid) strict_mode <= cfg.strict_mode;
      unique case (seq)
        SQ_IDLE: begin
          if (txt.valid) seq <= SQ_STEP;
        end
        SQ_STEP: begin
          pst <= step.st;
          cnt <= step.cnt;
          idx <= 1'b0;
          seq <= (step.cnt == 2'd0) ? SQ_IDLE : SQ_LOAD;
        end
        SQ_LOAD: seq <= cur.timed ? SQ_DIVGO : SQ_OUT;
        SQ_DIVGO: seq <= SQ_DIV;
        SQ_DIV: begin
          if (div_done) seq <= SQ_OUT;
        end
        SQ_OUT: begin
          if (evt.ready) begin
            if (idx || cnt == 2'd1) begin
              seq <= SQ_IDLE;
            end else begin
              idx <= 1'b1;
              seq <= SQ_LOAD;
            end
          end
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (seq == SQ_IDLE && txt.valid) begin
      chr <= txt.character;
      lst <= txt.last;
    end
    if (seq == SQ_STEP) begin
      res0 <= step.r0;
      res1 <= step.r1;
    end
    if (seq == SQ_LOAD) begin
      den             <= 24'(cur.len) * 24'(cur.tempo);
      evt.kind        <= cur.kind;
      evt.frequency   <= cur.freq;
      evt.duration_ms <= '0;
      evt.value       <= cur.value;
      evt.done_res    <= lst && (idx || cnt == 2'd1);
    end
    if (seq == SQ_DIV && div_done) evt.duration_ms <= div_q;
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    evt.valid |-> !txt.ready) else $error("input taken while an event is pending");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.ready && evt.done_res |=> txt.ready)
    else $error("final event did not return to idle");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> seq == SQ_DIV) else $error("divider finished outside its wait");

  a_oct_range: assert property (@(posedge clk) disable iff (rst)
    pst.oct <= 3'd6) else $error("octave out of range");

endmodule

[tb/mml_text_to_note_events_tb.sv]
// self-checking testbench for mml_text_to_note_events: drives macro text and strict_mode,
// predicts note, rest and control events and compares them one by one
// depends on mml_pkg, mml_in_if, mml_out_if, mml_cfg_if and the block itself
typedef struct packed {
  logic [2:0]  kind;
  logic [18:0] freq;
  logic [13:0] dur;
  logic [7:0]  value;
  logic        done;
} mml_event_t;

class mml_scoreboard;
  mml_event_t pending_events[$];
  int errors;
  int shown;
  logic strict;
  int ph;
  int unsigned acc;
  bit digit;
  int pitch;
  int dots;
  int oct;
  int tempo;
  int deflen;
  int vol;
  int art;
  int n_new;

  localparam int S_IDLE = 0, S_NMOD = 1, S_NNUM = 2, S_NDOT = 3, S_RNUM = 4, S_RDOT = 5,
    S_OCT = 6, S_TST = 7, S_TNUM = 8, S_TSKIP = 9, S_LEN = 10, S_VOL = 11, S_ART = 12,
    S_HALT = 13;

  function new();
    errors = 0;
    shown = 0;
    strict = 0;
    reset_text();
  endfunction

  function void clear_cmd();
    ph = S_IDLE;
    acc = 0;
    digit = 0;
    pitch = 0;
    dots = 0;
  endfunction

  function void reset_text();
    clear_cmd();
    oct = 4;
    tempo = 120;
    deflen = 4;
    vol = 8;
    art = 0;
  endfunction

  function void push(mml_pkg::kind_t k, int f, int d, int v);
    mml_event_t e;
    if (n_new >= 2) return;
    e.kind = k;
    e.freq = 19'(f);
    e.dur = 14'(d);
    e.value = 8'(v);
    e.done = 0;
    pending_events = {pending_events, e};
    n_new++;
  endfunction

  function void add_digit(logic [7:0] c);
    longint v;
    v = longint'(acc) * 10 + (c - "0");
    acc = (v > 65535) ? 65535 : int'(v);
    digit = 1;
  endfunction

  function int note_ms();
    longint len;
    len = digit ? acc : deflen;
    if (len == 0) len = deflen;
    if (len == 0) len = 4;
    return int'((dots != 0 ? 360000 : 240000) / (len * tempo));
  endfunction

  function int note_freq();
    longint f;
    f = longint'(mml_pkg::pitch_q16(4'(pitch % 12))) << oct;
    f = f >> 12;
    return (f > 524287) ? 524287 : int'(f);
  endfunction

  function void close_cmd();
    case (ph)
      S_NMOD, S_NNUM, S_NDOT: push(mml_pkg::K_NOTE, note_freq(), note_ms(), 0);
      S_RNUM, S_RDOT: push(mml_pkg::K_REST, 0, note_ms(), 0);
      S_OCT: begin
        if (digit) oct = acc > 6 ? 6 : acc;
        push(mml_pkg::K_OCTAVE, 0, 0, oct);
      end
      S_TST, S_TNUM: begin
        if (digit) tempo = acc < 32 ? 32 : (acc > 255 ? 255 : acc);
        push(mml_pkg::K_TEMPO, 0, 0, tempo);
      end
      S_LEN: if (digit) deflen = (acc >= 1 && acc <= 64) ? acc : 4;
      S_VOL: begin
        if (digit) vol = acc > 15 ? 15 : acc;
        push(mml_pkg::K_VOLUME, 0, 0, vol);
      end
      default: ;
    endcase
    if (ph != S_HALT) clear_cmd();
  endfunction

  function bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit grow_cmd(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 32 : c;
    case (ph)
      S_NMOD, S_NNUM: begin
        if (ph == S_NMOD && (c == "#" || c == "+")) begin
          pitch = (pitch + 1) % 12;
          ph = S_NNUM;
          return 1;
        end
        if (ph == S_NMOD && c == "-") begin
          pitch = (pitch + 11) % 12;
          ph = S_NNUM;
          return 1;
        end
        if (is_dig(c)) begin
          add_digit(c);
          ph = S_NNUM;
          return 1;
        end
        if (c == ".") begin
          dots = 1;
          ph = S_NDOT;
          return 1;
        end
        return 0;
      end
      S_NDOT: begin
        if (c == "." && dots < 3) begin
          dots++;
          return 1;
        end
        return 0;
      end
      S_RNUM: begin
        if (is_dig(c)) begin
          add_digit(c);
          return 1;
        end
        if (c == ".") begin
          dots = 1;
          ph = S_RDOT;
          return 1;
        end
        return 0;
      end
      S_RDOT: begin
        if (c == ".") begin
          if (dots < 3) dots++;
          return 1;
        end
        return 0;
      end
      S_OCT, S_LEN, S_VOL, S_TNUM: begin
        if (is_dig(c)) begin
          add_digit(c);
          return 1;
        end
        return 0;
      end
      S_TST: begin
        if (c == "=") begin
          ph = S_TSKIP;
          return 1;
        end
        if (is_dig(c)) begin
          add_digit(c);
          ph = S_TNUM;
          return 1;
        end
        return 0;
      end
      S_TSKIP: begin
        if ((u >= "A" && u <= "Z") || c == "<" || c == ">") begin
          clear_cmd();
          return 0;
        end
        return 1;
      end
      S_ART: begin
        if (u == "L") art = 1;
        else if (u == "N") art = 0;
        else if (u == "S") art = 2;
        push(mml_pkg::K_ARTIC, 0, 0, art);
        clear_cmd();
        return 1;
      end
      S_HALT: return 1;
      default: return 0;
    endcase
  endfunction

  function void start_cmd(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 32 : c;
    acc = 0;
    digit = 0;
    dots = 0;
    if (c == " " || (c >= 9 && c <= 13)) return;
    if (u >= "A" && u <= "G") begin
      pitch = mml_pkg::letter_pitch(3'(u - "A"));
      ph = S_NMOD;
      return;
    end
    case (u)
      "R", "P": ph = S_RNUM;
      "O": ph = S_OCT;
      "T": ph = S_TST;
      "L": ph = S_LEN;
      "V": ph = S_VOL;
      "M": ph = S_ART;
      "<": begin
        oct = oct ? oct - 1 : 0;
        push(mml_pkg::K_OCTAVE, 0, 0, oct);
      end
      ">": begin
        oct = oct >= 6 ? 6 : oct + 1;
        push(mml_pkg::K_OCTAVE, 0, 0, oct);
      end
      default: if (strict) begin
        push(mml_pkg::K_ERROR, 0, 0, 0);
        ph = S_HALT;
      end
    endcase
  endfunction

  function void note_input(logic [7:0] c, logic last);
    n_new = 0;
    if (ph == S_IDLE || !grow_cmd(c)) begin
      if (ph != S_IDLE) close_cmd();
      if (ph == S_IDLE) start_cmd(c);
    end
    if (last) begin
      close_cmd();
      if (n_new == 0) push(mml_pkg::K_END, 0, 0, 0);
      pending_events[$].done = 1;
      reset_text();
    end
  endfunction

  function void check_event(mml_event_t got);
    mml_event_t want;
    if (pending_events.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected event kind %0d value %0d", got.kind, got.value);
      end
      return;
    end
    want = pending_events.pop_front();
    if (got !== want) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("event mismatch: exp k%0d f%0d d%0d v%0d e%0d, got k%0d f%0d d%0d v%0d e%0d",
          want.kind, want.freq, want.dur, want.value, want.done,
          got.kind, got.freq, got.dur, got.value, got.done);
      end
    end
  endfunction
endclass

module mml_text_to_note_events_tb;
  logic clk = 0;
  logic rst = 1;
  mml_in_if txt();
  mml_out_if evt();
  mml_cfg_if cfg();
  mml_scoreboard sb;
  bit calm = 0;
  int idle_cycles = 0;

  mml_text_to_note_events u_dut (.clk(clk), .rst(rst), .txt(txt), .evt(evt), .cfg(cfg));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // output side: random stall bursts
  initial begin
    int stall;
    evt.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        evt.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      evt.ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    mml_event_t e;
    if (!rst && evt.valid && evt.ready) begin
      e.kind = evt.kind;
      e.freq = evt.frequency;
      e.dur = evt.duration_ms;
      e.value = evt.value;
      e.done = evt.done_res;
      sb.check_event(e);
    end
  end

  always @(posedge clk) begin
    if ((txt.valid && txt.ready) || (evt.valid && evt.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("mml_text_to_note_events_tb: errors");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    if (!calm && $urandom_range(0, 6) == 0) begin
      txt.valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    txt.valid <= 1;
    txt.character <= c;
    txt.last <= last;
    @(posedge clk);
    while (!txt.ready) @(posedge clk);
    sb.note_input(c, last);
  endtask

  task automatic drain();
    txt.valid <= 0;
    @(posedge clk);
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_strict(logic s);
    drain();
    cfg.valid <= 1;
    cfg.strict_mode <= s;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    sb.strict = s;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    string cmds = "ABCDEFGabcdefgRrPpOoTtLlVvMm<>";
    string modes = "NSLFnslf";
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cmds[$urandom_range(0, cmds.len() - 1)];
    if (r < 70) return 8'("0" + $urandom_range(0, 9));
    if (r < 78) return ".";
    if (r < 84) return ($urandom_range(0, 2) == 0) ? "#" : (($urandom_range(0, 1)) ? "+" : "-");
    if (r < 88) return "=";
    if (r < 92) return " ";
    if (r < 95) return modes[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int sent;
    int n;
    txt.valid = 0;
    txt.character = 0;
    txt.last = 0;
    cfg.valid = 0;
    cfg.strict_mode = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_text("c d+4 e-8. f#16... g.... a b");
    send_text("o9 o0 < > > > > > > > t1 t300 t65535999 T=5 x c");
    send_text("l0 c l65 c l64 c l1 c0 r r0... p2. v20 v mf ml ms mn m");
    write_strict(1);
    send_text("c!cde");
    send_text("o6c#1t32");
    send_char(8'hff, 1);
    write_strict(0);
    sent = 0;
    while (sent < 1650) begin
      if (sent > 800 && sent < 820) begin
        drain();
        write_strict($urandom_range(0, 1));
      end
      if (sent > 1450) calm = 1;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        logic [7:0] c;
        c = pick_char();
        if (sb.strict && $urandom_range(0, 3) != 0 && !(c inside {"!", 8'hff}))
          c = (c >= 8'h80) ? "c" : c;
        send_char(c, i == n - 1);
      end
      sent += n;
    end
    drain();
    if (sb.errors == 0)
      $display("mml_text_to_note_events_tb: clean");
    else
      $display("mml_text_to_note_events_tb: errors");
    $finish;
  end
endmodule
